@@ rtl/core/gamepad_poll_translate_core_macros.svh @@
// Assertion macros for the gamepad poll translate core.
// Included by the top level; uses no other file.
`ifndef GAMEPAD_POLL_TRANSLATE_CORE_MACROS_SVH
`define GAMEPAD_POLL_TRANSLATE_CORE_MACROS_SVH

// Check a property on a given clock, off while the given reset is low
`define GPT_ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check a property on the core clock and reset
`define GPT_ASSERT(lbl, prop, msg) `GPT_ASSERT_CLK(lbl, clk_i, rst_ni, prop, msg)

`endif

@@ rtl/core/gpt_pkg.sv @@
// Package for the gamepad poll translate core: frame constants, byte codes
// and the result word type. Depends on nothing.
package gpt_pkg;

  // Frame geometry
  localparam int unsigned FRAME_LEN = 9;
  localparam int unsigned POS_W     = 4;

  localparam logic [POS_W-1:0] POS_FIRST = 4'd0;
  localparam logic [POS_W-1:0] POS_MODE  = 4'd1;
  localparam logic [POS_W-1:0] POS_SMALL = 4'd2;
  localparam logic [POS_W-1:0] POS_LARGE = 4'd3;
  localparam logic [POS_W-1:0] POS_LAST  = 4'd8;

  // Command codes of the input word
  localparam logic CMD_START = 1'b0;
  localparam logic CMD_RX    = 1'b1;

  // Bytes on the wire
  localparam logic [7:0] TX_START     = 8'h01;
  localparam logic [7:0] TX_POLL      = 8'h42;
  localparam logic [7:0] TX_IDLE      = 8'h00;
  localparam logic [7:0] MODE_DIGITAL = 8'h41;
  localparam logic [7:0] MODE_ANALOG  = 8'h73;
  localparam logic [7:0] STICK_CENTER = 8'h80;
  localparam logic [7:0] STICK_FLIP   = 8'h7F;

  // One result word
  typedef struct packed {
    logic [7:0] tx_byte;
    logic       attention_hold;
    logic       frame_done;
    logic       frame_valid;
    logic [7:0] dpad_buttons;
    logic [7:0] face_buttons;
    logic [7:0] right_x;
    logic [7:0] right_y;
    logic [7:0] left_x;
    logic [7:0] left_y;
  } res_t;

endpackage

@@ rtl/core/gamepad_poll_translate_core.sv @@
// Top level of the gamepad poll translate core: frame sequencer, report
// translation and a two-word output buffer. Depends on gpt_pkg and the macros header.

// Each accepted input word yields exactly one result word. A word is taken on
// every cycle that in_stall_o is low: all of its work is done in the cycle it
// is accepted and the result is registered. The output side holds two words (an
// output register and a skid register); in_stall_o rises only when both are
// full, so a single stalled result never stops the input. Sustained rate is one
// word per cycle while the output is drained.
module gamepad_poll_translate_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic              command_i,
  input  logic [7:0]        rx_byte_i,
  input  logic [7:0]        rumble_small_i,
  input  logic [7:0]        rumble_large_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [7:0]        tx_byte_o,
  output logic              attention_hold_o,
  output logic              frame_done_o,
  output logic              frame_valid_o,
  output logic [7:0]        dpad_buttons_o,
  output logic [7:0]        face_buttons_o,
  output logic signed [7:0] right_x_o,
  output logic signed [7:0] right_y_o,
  output logic signed [7:0] left_x_o,
  output logic signed [7:0] left_y_o
);

  `include "gamepad_poll_translate_core_macros.svh"

  // Frame state
  logic [gpt_pkg::POS_W-1:0] pos_q, pos_d;
  logic                      active_q, active_d;
  logic [7:0]                rumble_small_q, rumble_small_d;
  logic [7:0]                rumble_large_q, rumble_large_d;
  logic [7:0]                frame_bytes_q [gpt_pkg::FRAME_LEN];
  logic [7:0]                frame_bytes_d [gpt_pkg::FRAME_LEN];

  // Output buffer
  logic              out_vld_q, out_vld_d;
  logic              skid_vld_q, skid_vld_d;
  gpt_pkg::res_t     out_res_q, out_res_d;
  gpt_pkg::res_t     skid_res_q, skid_res_d;
  gpt_pkg::res_t     res;

  logic in_accept;
  logic out_take;
  logic is_analog;
  logic [7:0] b3_n, b4_n;

  assign in_stall_o = skid_vld_q;
  assign in_accept  = in_valid_i && !skid_vld_q;
  assign out_take   = out_vld_q && !out_stall_i;

  assign is_analog = (frame_bytes_q[gpt_pkg::POS_MODE] == gpt_pkg::MODE_ANALOG);
  assign b3_n      = ~frame_bytes_q[3];
  assign b4_n      = ~frame_bytes_q[4];

  // Sequence the frame and build the result word for the incoming word
  always_comb begin
    pos_d          = pos_q;
    active_d       = active_q;
    rumble_small_d = rumble_small_q;
    rumble_large_d = rumble_large_q;
    frame_bytes_d  = frame_bytes_q;
    res            = '0;

    if (in_accept) begin
      if (command_i == gpt_pkg::CMD_START) begin
        rumble_small_d     = rumble_small_i;
        rumble_large_d     = rumble_large_i;
        for (int i = 0; i < gpt_pkg::FRAME_LEN; i++) begin
          frame_bytes_d[i] = '0;
        end
        pos_d              = gpt_pkg::POS_FIRST;
        active_d           = 1'b1;
        res.tx_byte        = gpt_pkg::TX_START;
        res.attention_hold = 1'b1;
      end else if (active_q) begin
        if (pos_q > gpt_pkg::POS_LAST) begin
          // Out-of-range position: end the frame invalid
          active_d       = 1'b0;
          pos_d          = gpt_pkg::POS_FIRST;
          res.frame_done = 1'b1;
        end else begin
          frame_bytes_d[pos_q] = rx_byte_i;
          if (pos_q == gpt_pkg::POS_MODE && rx_byte_i != gpt_pkg::MODE_DIGITAL &&
              rx_byte_i != gpt_pkg::MODE_ANALOG) begin
            // Unknown mode: drop the frame with a neutral report
            active_d       = 1'b0;
            pos_d          = gpt_pkg::POS_FIRST;
            res.frame_done = 1'b1;
          end else if (pos_q == gpt_pkg::POS_LAST) begin
            // Last byte: translate the report
            active_d         = 1'b0;
            pos_d            = gpt_pkg::POS_FIRST;
            res.frame_done   = 1'b1;
            res.frame_valid  = 1'b1;
            res.dpad_buttons = {b3_n[2], b3_n[1], b3_n[0], b3_n[3],
                                b3_n[5], b3_n[7], b3_n[6], b3_n[4]};
            res.face_buttons = {b4_n[3], b4_n[2], b4_n[1], b4_n[0],
                                b4_n[4], b4_n[7], b4_n[5], b4_n[6]};
            if (is_analog) begin
              res.right_x = frame_bytes_q[5] ^ gpt_pkg::STICK_CENTER;
              res.right_y = frame_bytes_q[6] ^ gpt_pkg::STICK_FLIP;
              res.left_x  = frame_bytes_q[7] ^ gpt_pkg::STICK_CENTER;
              res.left_y  = rx_byte_i ^ gpt_pkg::STICK_FLIP;
            end
          end else begin
            // Mid-frame: pick the next byte to shift out
            case (pos_q)
              gpt_pkg::POS_FIRST: res.tx_byte = gpt_pkg::TX_POLL;
              gpt_pkg::POS_SMALL: res.tx_byte = is_analog ? rumble_small_q : gpt_pkg::TX_IDLE;
              gpt_pkg::POS_LARGE: res.tx_byte = is_analog ? rumble_large_q : gpt_pkg::TX_IDLE;
              default:            res.tx_byte = gpt_pkg::TX_IDLE;
            endcase
            res.attention_hold = 1'b1;
            pos_d              = pos_q + 1'b1;
          end
        end
      end
    end
  end

  // Steer results into the output register or the skid register
  always_comb begin
    out_vld_d  = out_vld_q;
    skid_vld_d = skid_vld_q;
    out_res_d  = out_res_q;
    skid_res_d = skid_res_q;
    if (!out_vld_q || out_take) begin
      if (skid_vld_q) begin
        out_res_d  = skid_res_q;
        out_vld_d  = 1'b1;
        skid_vld_d = 1'b0;
      end else begin
        out_res_d  = res;
        out_vld_d  = in_accept;
      end
    end else if (in_accept) begin
      skid_res_d = res;
      skid_vld_d = 1'b1;
    end
  end

  // Control and frame state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q          <= gpt_pkg::POS_FIRST;
      active_q       <= 1'b0;
      rumble_small_q <= '0;
      rumble_large_q <= '0;
      for (int i = 0; i < gpt_pkg::FRAME_LEN; i++) begin
        frame_bytes_q[i] <= '0;
      end
      out_vld_q      <= 1'b0;
      skid_vld_q     <= 1'b0;
    end else begin
      pos_q          <= pos_d;
      active_q       <= active_d;
      rumble_small_q <= rumble_small_d;
      rumble_large_q <= rumble_large_d;
      frame_bytes_q  <= frame_bytes_d;
      out_vld_q      <= out_vld_d;
      skid_vld_q     <= skid_vld_d;
    end
  end

  // Result payload registers
  always_ff @(posedge clk_i) begin
    out_res_q  <= out_res_d;
    skid_res_q <= skid_res_d;
  end

  // Drive the output word
  assign out_valid_o      = out_vld_q;
  assign tx_byte_o        = out_res_q.tx_byte;
  assign attention_hold_o = out_res_q.attention_hold;
  assign frame_done_o     = out_res_q.frame_done;
  assign frame_valid_o    = out_res_q.frame_valid;
  assign dpad_buttons_o   = out_res_q.dpad_buttons;
  assign face_buttons_o   = out_res_q.face_buttons;
  assign right_x_o        = $signed(out_res_q.right_x);
  assign right_y_o        = $signed(out_res_q.right_y);
  assign left_x_o         = $signed(out_res_q.left_x);
  assign left_y_o         = $signed(out_res_q.left_y);

  // Assertions
  logic start_take;
  logic frame_open;
  logic out_done;

  assign start_take = in_accept && (command_i == gpt_pkg::CMD_START);
  assign frame_open = active_q && (pos_q == gpt_pkg::POS_FIRST);
  assign out_done   = out_vld_q && out_res_q.frame_done;

  `GPT_ASSERT(a_skid_needs_out, skid_vld_q |-> out_vld_q, "skid word without output word")
  `GPT_ASSERT(a_idle_pos_zero, !active_q |-> (pos_q == gpt_pkg::POS_FIRST), "stray position")
  `GPT_ASSERT(a_pos_range, pos_q <= gpt_pkg::POS_LAST, "frame position out of range")
  `GPT_ASSERT(a_done_releases, out_done |-> !out_res_q.attention_hold, "attention held at end")
  `GPT_ASSERT(a_start_opens, start_take |=> frame_open, "start did not open a frame")

endmodule

@@ sim/gamepad_poll_translate_core_test.sv @@
// Self-checking bench for gamepad_poll_translate_core: poll frames through the input port,
// results compared word by word against a frame predictor.
// Depends on gpt_pkg and the core RTL only.
module gamepad_poll_translate_core_test;

  localparam int ITEM_TARGET    = 1300;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int HOLD_OFF_LEN   = 400;

  // Frame byte positions that carry buttons and sticks
  localparam int BYTE_DPAD = 3;
  localparam int BYTE_FACE = 4;
  localparam int BYTE_RX   = 5;
  localparam int BYTE_RY   = 6;
  localparam int BYTE_LX   = 7;
  localparam int BYTE_LY   = 8;

  // Track one frame in progress and the report words it should yield
  class poll_frame_board;
    gpt_pkg::res_t pending_reports[$];
    int            errors;
    logic [3:0]    frame_pos;
    logic [7:0]    frame_copy[gpt_pkg::FRAME_LEN];
    logic [7:0]    small_lvl;
    logic [7:0]    large_lvl;
    bit            in_frame;

    function new();
      errors    = 0;
      frame_pos = gpt_pkg::POS_FIRST;
      foreach (frame_copy[i]) frame_copy[i] = 8'h00;
      small_lvl = 8'h00;
      large_lvl = 8'h00;
      in_frame  = 0;
    endfunction

    task flag_mismatch(string msg);
      $display("%0t mismatch: %s", $time, msg);
      errors++;
    endtask

    // Predict the word for an accepted input; return 0 when the block ignores it
    function bit note_word(logic cmd, logic [7:0] rx, logic [7:0] rs, logic [7:0] rl);
      gpt_pkg::res_t r;
      bit            took;
      bit            analog;
      logic [7:0]    lo_dpad;
      logic [7:0]    lo_face;
      r    = '0;
      took = 1;
      if (cmd == gpt_pkg::CMD_START) begin
        small_lvl = rs;
        large_lvl = rl;
        foreach (frame_copy[i]) frame_copy[i] = 8'h00;
        frame_pos        = gpt_pkg::POS_FIRST;
        in_frame         = 1;
        r.tx_byte        = gpt_pkg::TX_START;
        r.attention_hold = 1'b1;
      end else if (!in_frame) begin
        took = 0;
      end else begin
        frame_copy[frame_pos] = rx;
        analog = (frame_copy[gpt_pkg::POS_MODE] == gpt_pkg::MODE_ANALOG);
        if (frame_pos == gpt_pkg::POS_MODE && rx != gpt_pkg::MODE_DIGITAL &&
            rx != gpt_pkg::MODE_ANALOG) begin
          // bad mode: end the frame with a neutral report
          in_frame     = 0;
          frame_pos    = gpt_pkg::POS_FIRST;
          r.frame_done = 1'b1;
        end else if (frame_pos == gpt_pkg::POS_LAST) begin
          in_frame      = 0;
          frame_pos     = gpt_pkg::POS_FIRST;
          r.frame_done  = 1'b1;
          r.frame_valid = 1'b1;
          // buttons arrive active low; remap to report order
          lo_dpad = ~frame_copy[BYTE_DPAD];
          lo_face = ~frame_copy[BYTE_FACE];
          r.dpad_buttons = {lo_dpad[2], lo_dpad[1], lo_dpad[0], lo_dpad[3],
                            lo_dpad[5], lo_dpad[7], lo_dpad[6], lo_dpad[4]};
          r.face_buttons = {lo_face[3], lo_face[2], lo_face[1], lo_face[0],
                            lo_face[4], lo_face[7], lo_face[5], lo_face[6]};
          if (analog) begin
            r.right_x = frame_copy[BYTE_RX] - gpt_pkg::STICK_CENTER;
            r.right_y = ~(frame_copy[BYTE_RY] - gpt_pkg::STICK_CENTER);
            r.left_x  = frame_copy[BYTE_LX] - gpt_pkg::STICK_CENTER;
            r.left_y  = ~(frame_copy[BYTE_LY] - gpt_pkg::STICK_CENTER);
          end
        end else begin
          case (frame_pos)
            gpt_pkg::POS_FIRST: r.tx_byte = gpt_pkg::TX_POLL;
            gpt_pkg::POS_SMALL: r.tx_byte = analog ? small_lvl : gpt_pkg::TX_IDLE;
            gpt_pkg::POS_LARGE: r.tx_byte = analog ? large_lvl : gpt_pkg::TX_IDLE;
            default:            r.tx_byte = gpt_pkg::TX_IDLE;
          endcase
          r.attention_hold = 1'b1;
          frame_pos        = frame_pos + 4'd1;
        end
      end
      pending_reports.push_back(r);
      return took;
    endfunction

    task match_field(string name, logic [7:0] got, logic [7:0] exp);
      if (got !== exp)
        flag_mismatch($sformatf("%s got %h expected %h", name, got, exp));
    endtask

    // Compare a delivered word with the oldest prediction
    task check_word(gpt_pkg::res_t got);
      gpt_pkg::res_t exp;
      if (pending_reports.size() == 0) begin
        flag_mismatch("result word with nothing expected");
        return;
      end
      exp = pending_reports.pop_front();
      match_field("tx_byte",        got.tx_byte,        exp.tx_byte);
      match_field("attention_hold", got.attention_hold, exp.attention_hold);
      match_field("frame_done",     got.frame_done,     exp.frame_done);
      match_field("frame_valid",    got.frame_valid,    exp.frame_valid);
      match_field("dpad_buttons",   got.dpad_buttons,   exp.dpad_buttons);
      match_field("face_buttons",   got.face_buttons,   exp.face_buttons);
      match_field("right_x",        got.right_x,        exp.right_x);
      match_field("right_y",        got.right_y,        exp.right_y);
      match_field("left_x",         got.left_x,         exp.left_x);
      match_field("left_y",         got.left_y,         exp.left_y);
    endtask
  endclass

  logic        clk_i;
  logic        rst_ni         = 1'b0;
  logic        in_valid       = 1'b0;
  logic        command        = gpt_pkg::CMD_START;
  logic [7:0]  rx_byte        = 8'h00;
  logic [7:0]  rumble_small   = 8'h00;
  logic [7:0]  rumble_large   = 8'h00;
  logic        out_stall      = 1'b0;
  logic        in_stall_o;
  logic        out_valid_o;
  logic [7:0]  tx_byte_o;
  logic        attention_hold_o;
  logic        frame_done_o;
  logic        frame_valid_o;
  logic [7:0]  dpad_buttons_o;
  logic [7:0]  face_buttons_o;
  logic signed [7:0] right_x_o;
  logic signed [7:0] right_y_o;
  logic signed [7:0] left_x_o;
  logic signed [7:0] left_y_o;

  poll_frame_board board = new();
  int words_sent     = 0;
  int send_gap_pct   = 0;
  int sink_stall_pct = 0;
  int hold_left      = 0;
  int quiet_cycles   = 0;

  gamepad_poll_translate_core u_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid),
    .in_stall_o       (in_stall_o),
    .command_i        (command),
    .rx_byte_i        (rx_byte),
    .rumble_small_i   (rumble_small),
    .rumble_large_i   (rumble_large),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall),
    .tx_byte_o        (tx_byte_o),
    .attention_hold_o (attention_hold_o),
    .frame_done_o     (frame_done_o),
    .frame_valid_o    (frame_valid_o),
    .dpad_buttons_o   (dpad_buttons_o),
    .face_buttons_o   (face_buttons_o),
    .right_x_o        (right_x_o),
    .right_y_o        (right_y_o),
    .left_x_o         (left_x_o),
    .left_y_o         (left_y_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Stall the output side: long hold-off when requested, else random
  always @(posedge clk_i) begin
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < sink_stall_pct);
    end
  end

  // Check every result word taken from the block
  always @(posedge clk_i) begin
    gpt_pkg::res_t got;
    if (rst_ni && out_valid_o && !out_stall) begin
      got.tx_byte        = tx_byte_o;
      got.attention_hold = attention_hold_o;
      got.frame_done     = frame_done_o;
      got.frame_valid    = frame_valid_o;
      got.dpad_buttons   = dpad_buttons_o;
      got.face_buttons   = face_buttons_o;
      got.right_x        = right_x_o;
      got.right_y        = right_y_o;
      got.left_x         = left_x_o;
      got.left_y         = left_y_o;
      board.check_word(got);
    end
  end

  // Abort when neither side moves a word for too long
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid && !in_stall_o) || (out_valid_o && !out_stall))
        quiet_cycles = 0;
      else
        quiet_cycles = quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  // Offer one word after a random gap and hold it until taken
  task automatic send_word(input logic cmd, input logic [7:0] rx,
                           input logic [7:0] rs, input logic [7:0] rl);
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid     <= 1'b1;
    command      <= cmd;
    rx_byte      <= rx;
    rumble_small <= rs;
    rumble_large <= rl;
    do @(posedge clk_i); while (in_stall_o);
    if (board.note_word(cmd, rx, rs, rl)) words_sent++;
  endtask

  // Start a frame and feed the first n controller bytes of it
  task automatic play_frame(input logic [7:0] rs, input logic [7:0] rl,
                            input logic [7:0] seq[gpt_pkg::FRAME_LEN], input int n);
    send_word(gpt_pkg::CMD_START, 8'($urandom_range(255)), rs, rl);
    for (int i = 0; i < n; i++)
      send_word(gpt_pkg::CMD_RX, seq[i], 8'($urandom_range(255)), 8'($urandom_range(255)));
  endtask

  // Stop offering and wait until every predicted word has come out
  task automatic drain_reports();
    in_valid <= 1'b0;
    while (board.pending_reports.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(7))
      0:       return 8'h00;
      1:       return 8'hFF;
      2:       return gpt_pkg::STICK_CENTER;
      3:       return gpt_pkg::STICK_FLIP;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  // One random frame: mostly complete, some bad mode, some abandoned, some stray bytes
  task automatic random_frame();
    logic [7:0] seq[gpt_pkg::FRAME_LEN];
    logic [7:0] bad;
    int         kind;
    int         n;
    kind = $urandom_range(99);
    n    = gpt_pkg::FRAME_LEN;
    foreach (seq[i]) seq[i] = pick_byte();
    if (kind < 50) begin
      seq[gpt_pkg::POS_MODE] = gpt_pkg::MODE_ANALOG;
    end else if (kind < 85) begin
      seq[gpt_pkg::POS_MODE] = gpt_pkg::MODE_DIGITAL;
    end else begin
      do bad = 8'($urandom_range(255));
      while (bad == gpt_pkg::MODE_DIGITAL || bad == gpt_pkg::MODE_ANALOG);
      seq[gpt_pkg::POS_MODE] = bad;
      n = 2;
    end
    if ($urandom_range(99) < 8) n = $urandom_range(gpt_pkg::FRAME_LEN - 1);
    play_frame(pick_byte(), pick_byte(), seq, n);
    if ($urandom_range(99) < 10)
      repeat ($urandom_range(2, 1))
        send_word(gpt_pkg::CMD_RX, 8'($urandom_range(255)), 8'($urandom_range(255)),
                  8'($urandom_range(255)));
  endtask

  initial begin
    logic [7:0] seq[gpt_pkg::FRAME_LEN];
    int         target;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: stray byte, analog and digital frames at the extremes, bad mode
    send_word(gpt_pkg::CMD_RX, 8'hFF, 8'hFF, 8'hFF);
    seq = '{8'hFF, gpt_pkg::MODE_ANALOG, 8'h5A, 8'h00, 8'hFF, 8'h00, 8'hFF,
            gpt_pkg::STICK_CENTER, gpt_pkg::STICK_FLIP};
    play_frame(8'hFF, 8'h00, seq, gpt_pkg::FRAME_LEN);
    seq = '{8'h00, gpt_pkg::MODE_DIGITAL, 8'hA5, 8'hFF, 8'h00, gpt_pkg::STICK_FLIP,
            gpt_pkg::STICK_CENTER, 8'hFF, 8'h00};
    play_frame(8'h00, 8'hFF, seq, gpt_pkg::FRAME_LEN);
    seq = '{8'h00, 8'h74, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00};
    play_frame(8'h12, 8'h34, seq, 2);
    send_word(gpt_pkg::CMD_RX, 8'h00, 8'h00, 8'h00);
    drain_reports();

    // Random frames over four idling phases
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_gap_pct = 0;  sink_stall_pct = 0;  end
        1: begin send_gap_pct = 73; sink_stall_pct = 0;  end
        2: begin send_gap_pct = 0;  sink_stall_pct = 73; end
        default: begin send_gap_pct = 13; sink_stall_pct = 13; end
      endcase
      // hold the output off so the block fills and stalls its input
      if (ph == 0) hold_left = HOLD_OFF_LEN;
      target = (ph + 1) * ITEM_TARGET / 4;
      while (words_sent < target) random_frame();
      drain_reports();
    end

    repeat (4) @(posedge clk_i);
    if (board.pending_reports.size() != 0)
      board.flag_mismatch("expected words left over");
    if (board.errors == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule
